FILE: src/dsseg_pkg.sv
// shared types, constants and the segment table for the decimal seven-segment
// serial driver
// no dependencies
`default_nettype none

package dsseg_pkg;

   localparam int DIGIT_COUNT_DEF = 6;
   localparam int VALUE_W         = 17;
   localparam int BCD_DIGITS      = 6;   // enough decimal digits for any 17-bit value
   localparam int CODE_W          = 8;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [VALUE_W-1:0] BLANK_LIMIT = VALUE_W'(100000);
   localparam logic [CODE_W-1:0]  SEG_BLANK   = 8'h00;
   localparam logic [CODE_W-1:0]  POINT_MASK  = 8'h01;

   typedef struct packed {
      logic               display_index;
      logic [VALUE_W-1:0] shown_value;
   } req_type;

   typedef struct packed {
      logic target_display;
      logic serial_bit;
      logic last_bit;
   } rsp_type;

   // segments a..g on bits 7..1, point on bit 0
   function automatic logic [CODE_W-1:0] seg_code(input logic [3:0] digit);
      logic [CODE_W-1:0] code;
      begin
         unique case (digit)
            4'd0:    code = 8'hFC;
            4'd1:    code = 8'h60;
            4'd2:    code = 8'hDA;
            4'd3:    code = 8'hF2;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'hB6;
            4'd6:    code = 8'hBE;
            4'd7:    code = 8'hE4;
            4'd8:    code = 8'hFE;
            4'd9:    code = 8'hF6;
            default: code = SEG_BLANK;
         endcase
         return code;
      end
   endfunction

endpackage

`default_nettype wire

FILE: src/dsseg_front.sv
// front end: takes a word, converts the value to decimal one bit per cycle
// (shift-and-add-3) and hands the segment codes to the queue; uses dsseg_pkg
`default_nettype none

module dsseg_front #(
   parameter int DIGIT_COUNT = dsseg_pkg::DIGIT_COUNT_DEF
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       req_valid,
   output logic                                            req_ready,
   input  wire dsseg_pkg::req_type                         req_word,
   output logic                                            push,
   input  wire logic                                       push_ready,
   output logic [DIGIT_COUNT*dsseg_pkg::CODE_W:0]          push_data
);

   localparam int BCD_W = 4 * dsseg_pkg::BCD_DIGITS;
   localparam int CNT_W = $clog2(dsseg_pkg::VALUE_W);

   typedef enum logic [2:0] {
      FS_IDLE = 3'b001,
      FS_CONV = 3'b010,
      FS_PUSH = 3'b100
   } front_state_type;

   front_state_type                 state_ff, state_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [dsseg_pkg::VALUE_W-1:0]   val_ff, val_in;
   logic [BCD_W-1:0]                bcd_ff, bcd_in;
   logic                            disp_ff, disp_in;
   logic                            over_ff, over_in;
   logic [BCD_W-1:0]                bcd_adj;
   logic [DIGIT_COUNT*dsseg_pkg::CODE_W-1:0] codes;
   logic                            accept;

   assign req_ready = (state_ff == FS_IDLE) || ((state_ff == FS_PUSH) && push_ready);
   assign accept    = req_valid && req_ready;
   assign push      = (state_ff == FS_PUSH);
   assign push_data = {disp_ff, codes};

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int d = 0; d < dsseg_pkg::BCD_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   // code for weight 10^e sits at bits [8e +: 8], so the leftmost digit is on top
   for (genvar e = 0; e < DIGIT_COUNT; e++) begin : g_code
      if (e >= dsseg_pkg::BCD_DIGITS) begin : g_high
         assign codes[e*dsseg_pkg::CODE_W +: dsseg_pkg::CODE_W] = dsseg_pkg::SEG_BLANK;
      end else begin : g_digit
         logic upper_zero;
         logic [dsseg_pkg::CODE_W-1:0] raw;
         assign upper_zero = (bcd_ff[BCD_W-1:4*e] == '0);
         assign raw = dsseg_pkg::seg_code(bcd_ff[4*e +: 4])
                      | ((e == 1) ? dsseg_pkg::POINT_MASK : dsseg_pkg::SEG_BLANK);
         assign codes[e*dsseg_pkg::CODE_W +: dsseg_pkg::CODE_W] =
            (over_ff || ((e >= 2) && upper_zero)) ? dsseg_pkg::SEG_BLANK : raw;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      val_in   = val_ff;
      bcd_in   = bcd_ff;
      disp_in  = disp_ff;
      over_in  = over_ff;
      unique case (state_ff)
         FS_IDLE: begin
         end
         FS_CONV: begin
            bcd_in = {bcd_adj[BCD_W-2:0], val_ff[dsseg_pkg::VALUE_W-1]};
            val_in = {val_ff[dsseg_pkg::VALUE_W-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = FS_PUSH;
            end
         end
         FS_PUSH: begin
            if (push_ready) begin
               state_in = FS_IDLE;
            end
         end
         default: state_in = FS_IDLE;
      endcase
      if (accept) begin
         state_in = FS_CONV;
         cnt_in   = CNT_W'(dsseg_pkg::VALUE_W - 1);
         val_in   = req_word.shown_value;
         bcd_in   = '0;
         disp_in  = req_word.display_index;
         over_in  = (req_word.shown_value >= dsseg_pkg::BLANK_LIMIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      val_ff  <= val_in;
      bcd_ff  <= bcd_in;
      disp_ff <= disp_in;
      over_ff <= over_in;
   end

endmodule

`default_nettype wire

FILE: src/dsseg_queue.sv
// two-entry queue between the front end and the shifter
// depends on dsseg_pkg for its depth
`default_nettype none

module dsseg_queue #(
   parameter int WIDTH = 49
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int PTR_W = $clog2(dsseg_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(dsseg_pkg::QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [dsseg_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign push_ready = (fill_ff != CNT_W'(dsseg_pkg::QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = mem_ff[rd_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(dsseg_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(dsseg_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: src/dsseg_back.sv
// back end: shifts queued segment codes out into the output register one bit
// per cycle unless stalled, leftmost code first, msb first; uses dsseg_pkg
`default_nettype none

module dsseg_back #(
   parameter int DIGIT_COUNT = dsseg_pkg::DIGIT_COUNT_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    pop_valid,
   output logic                                         pop,
   input  wire logic [DIGIT_COUNT*dsseg_pkg::CODE_W:0]  pop_data,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output dsseg_pkg::rsp_type                           rsp_word
);

   localparam int TOTAL = DIGIT_COUNT * dsseg_pkg::CODE_W;
   localparam int CNT_W = $clog2(TOTAL);

   logic [TOTAL-1:0]   sh_ff, sh_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               active_ff, active_in;
   logic               disp_ff, disp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   dsseg_pkg::rsp_type rsp_ff, rsp_in;
   logic               advance;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign pop       = advance && !active_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_comb begin
      sh_in        = sh_ff;
      cnt_in       = cnt_ff;
      active_in    = active_ff;
      disp_in      = disp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         if (active_ff) begin
            rsp_valid_in          = 1'b1;
            rsp_in.target_display = disp_ff;
            rsp_in.serial_bit     = sh_ff[TOTAL-1];
            rsp_in.last_bit       = (cnt_ff == CNT_W'(1));
            sh_in                 = {sh_ff[TOTAL-2:0], 1'b0};
            cnt_in                = cnt_ff - CNT_W'(1);
            active_in             = (cnt_ff != CNT_W'(1));
         end else if (pop_valid) begin
            // first bit goes straight out so words follow with no gap
            rsp_valid_in          = 1'b1;
            rsp_in.target_display = pop_data[TOTAL];
            rsp_in.serial_bit     = pop_data[TOTAL-1];
            rsp_in.last_bit       = 1'b0;
            sh_in                 = {pop_data[TOTAL-2:0], 1'b0};
            disp_in               = pop_data[TOTAL];
            cnt_in                = CNT_W'(TOTAL - 1);
            active_in             = 1'b1;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sh_ff   <= sh_in;
      cnt_ff  <= cnt_in;
      disp_ff <= disp_in;
      rsp_ff  <= rsp_in;
   end

endmodule

`default_nettype wire

FILE: src/decimal_seven_segment_shift_out_top.sv
// top level of the decimal seven-segment serial driver
// instantiates dsseg_front, dsseg_queue and dsseg_back; uses dsseg_pkg
`default_nettype none

// Each request word names a display and a value in tenths. The value is shown
// on DIGIT_COUNT seven-segment positions: leading zeros blank down to the tens
// position, which always shows and carries the point; 100000 and above gives
// an all-dark display. Each word produces 8*DIGIT_COUNT response words (48 by
// default), one serial bit each, leftmost code first and msb first, with
// last_bit on the final one. The shifter emits one bit per cycle while the
// response side does not stall; new requests are taken no faster than the
// shifter or the front end's bit-serial decimal conversion allows. The front
// end runs ahead into a two-entry queue, so it can take a new request while
// earlier words are still being shifted out.

module decimal_seven_segment_shift_out_top #(
   parameter int DIGIT_COUNT = dsseg_pkg::DIGIT_COUNT_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire dsseg_pkg::req_type req_word,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output dsseg_pkg::rsp_type      rsp_word
);

   localparam int Q_W = DIGIT_COUNT * dsseg_pkg::CODE_W + 1;

   logic           push, push_ready;
   logic [Q_W-1:0] push_data;
   logic           pop_valid, pop;
   logic [Q_W-1:0] pop_data;

   dsseg_front #(
      .DIGIT_COUNT(DIGIT_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .push      (push),
      .push_ready(push_ready),
      .push_data (push_data)
   );

   dsseg_queue #(
      .WIDTH(Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_ready(push_ready),
      .push_data (push_data),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_data  (pop_data)
   );

   dsseg_back #(
      .DIGIT_COUNT(DIGIT_COUNT)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_valid(pop_valid),
      .pop      (pop),
      .pop_data (pop_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word (rsp_word)
   );

endmodule

`default_nettype wire

FILE: src/dsseg_checker.sv
// port-level checks for the decimal seven-segment serial driver
// bound to decimal_seven_segment_shift_out_top; uses dsseg_pkg
`default_nettype none

module dsseg_checker #(
   parameter int DIGIT_COUNT = dsseg_pkg::DIGIT_COUNT_DEF
) (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire dsseg_pkg::req_type req_word,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire dsseg_pkg::rsp_type rsp_word
);

   localparam int TOTAL = DIGIT_COUNT * dsseg_pkg::CODE_W;
   localparam int CNT_W = $clog2(TOTAL);

   logic [CNT_W-1:0] bits_ff, bits_in;
   logic             disp_ff, disp_in;
   logic             rsp_take;

   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      bits_in = bits_ff;
      disp_in = disp_ff;
      if (rsp_take) begin
         bits_in = (bits_ff == CNT_W'(TOTAL - 1)) ? '0 : bits_ff + CNT_W'(1);
         disp_in = rsp_word.target_display;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= '0;
      end else begin
         bits_ff <= bits_in;
      end
      disp_ff <= disp_in;
   end

   // last mark on exactly every final bit of a word
   a_last_position: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> (rsp_word.last_bit == (bits_ff == CNT_W'(TOTAL - 1))))
      else $error("last_bit out of place");

   // one display for all bits of a word
   a_display_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && (bits_ff != '0)) |-> (rsp_word.target_display == disp_ff))
      else $error("target_display changed inside a word");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> (req_valid && $stable(req_word)))
      else $error("waiting request changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled response changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind decimal_seven_segment_shift_out_top dsseg_checker #(
   .DIGIT_COUNT(DIGIT_COUNT)
) u_dsseg_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_word (req_word),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_word (rsp_word)
);

`default_nettype wire
